/* src/slt_pkg.sv */
// Shared types, character codes and sizes of the shell line tokenizer.
`default_nettype none

package slt_pkg;

  // Kinds of tokenizer events.
  typedef enum logic [2:0] {
    EvByte    = 3'd0,
    EvWordEnd = 3'd1,
    EvOut     = 3'd2,
    EvAppend  = 3'd3,
    EvIn      = 3'd4,
    EvHeredoc = 3'd5,
    EvPipe    = 3'd6,
    EvLineEnd = 3'd7
  } event_kind_e;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CharGt     = 8'h3E;
  localparam logic [7:0] CharLt     = 8'h3C;
  localparam logic [7:0] CharPipe   = 8'h7C;
  localparam logic [7:0] CharSQuote = 8'h27;
  localparam logic [7:0] CharDQuote = 8'h22;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  // One input byte causes at most this many events.
  localparam int unsigned MaxEvents = 4;
  localparam int unsigned EvIdxW    = $clog2(MaxEvents);
  localparam int unsigned EvCntW    = $clog2(MaxEvents + 1);

  // Bundles held between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  ch;
    logic        first;
  } event_t;

  // All events caused by one input byte, in order.
  typedef struct packed {
    event_t [MaxEvents-1:0] ev;
    logic   [EvCntW-1:0]    cnt;
  } bundle_t;

endpackage

`default_nettype wire

/* src/slt_front.sv */
// Front of the tokenizer: accepts bytes, tracks lexer state, builds event bundles.
`default_nettype none

module slt_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output      logic            ready_o,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  input  wire logic            queue_full_i,
  output      logic            push_o,
  output      slt_pkg::bundle_t bundle_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StWord = 6'b000010,
    StSq   = 6'b000100,
    StDq   = 6'b001000,
    StGt   = 6'b010000,
    StLt   = 6'b100000
  } lex_state_e;

  lex_state_e state_q, state_d;
  logic       accept;

  // Append one event to a bundle.
  function automatic slt_pkg::bundle_t add_ev(slt_pkg::bundle_t b,
                                              slt_pkg::event_kind_e kind,
                                              logic [7:0] ch, logic first);
    slt_pkg::bundle_t r;
    r = b;
    if (b.cnt < slt_pkg::EvCntW'(slt_pkg::MaxEvents)) begin
      r.ev[b.cnt[slt_pkg::EvIdxW-1:0]].kind  = kind;
      r.ev[b.cnt[slt_pkg::EvIdxW-1:0]].ch    = ch;
      r.ev[b.cnt[slt_pkg::EvIdxW-1:0]].first = first;
      r.cnt = b.cnt + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    slt_pkg::bundle_t b;
    lex_state_e       cur;
    logic             done;
    logic             is_ws;
    logic             is_op;
    b       = '0;
    cur     = StIdle;
    done    = 1'b0;
    state_d = state_q;
    is_ws   = (byte_i == 8'h00) || (byte_i == slt_pkg::CharSpace) ||
              ((byte_i >= slt_pkg::CharTab) && (byte_i <= slt_pkg::CharCr));
    is_op   = (byte_i == slt_pkg::CharGt) || (byte_i == slt_pkg::CharLt) ||
              (byte_i == slt_pkg::CharPipe);

    case (state_q)
      StSq: begin
        b = add_ev(b, slt_pkg::EvByte, byte_i, 1'b0);
        cur = (byte_i == slt_pkg::CharSQuote) ? StWord : StSq;
        done = 1'b1;
      end
      StDq: begin
        b = add_ev(b, slt_pkg::EvByte, byte_i, 1'b0);
        cur = (byte_i == slt_pkg::CharDQuote) ? StWord : StDq;
        done = 1'b1;
      end
      StGt: begin
        if (byte_i == slt_pkg::CharGt) begin
          b = add_ev(b, slt_pkg::EvAppend, 8'h00, 1'b0);
          done = 1'b1;
        end else begin
          b = add_ev(b, slt_pkg::EvOut, 8'h00, 1'b0);
        end
        cur = StIdle;
      end
      StLt: begin
        if (byte_i == slt_pkg::CharLt) begin
          b = add_ev(b, slt_pkg::EvHeredoc, 8'h00, 1'b0);
          done = 1'b1;
        end else begin
          b = add_ev(b, slt_pkg::EvIn, 8'h00, 1'b0);
        end
        cur = StIdle;
      end
      StWord: cur = StWord;
      default: cur = StIdle;
    endcase

    if (!done) begin
      if (is_ws) begin
        if (cur == StWord) b = add_ev(b, slt_pkg::EvWordEnd, 8'h00, 1'b0);
        cur = StIdle;
      end else if (is_op) begin
        if (cur == StWord) b = add_ev(b, slt_pkg::EvWordEnd, 8'h00, 1'b0);
        if (byte_i == slt_pkg::CharGt) begin
          cur = StGt;
        end else if (byte_i == slt_pkg::CharLt) begin
          cur = StLt;
        end else begin
          b = add_ev(b, slt_pkg::EvPipe, 8'h00, 1'b0);
          cur = StIdle;
        end
      end else begin
        b = add_ev(b, slt_pkg::EvByte, byte_i, cur != StWord);
        if (byte_i == slt_pkg::CharSQuote) cur = StSq;
        else if (byte_i == slt_pkg::CharDQuote) cur = StDq;
        else cur = StWord;
      end
    end

    if (last_i) begin
      if (cur == StWord || cur == StSq || cur == StDq) begin
        b = add_ev(b, slt_pkg::EvWordEnd, 8'h00, 1'b0);
      end else if (cur == StGt) begin
        b = add_ev(b, slt_pkg::EvOut, 8'h00, 1'b0);
      end else if (cur == StLt) begin
        b = add_ev(b, slt_pkg::EvIn, 8'h00, 1'b0);
      end
      b = add_ev(b, slt_pkg::EvLineEnd, 8'h00, 1'b0);
      cur = StIdle;
    end

    bundle_o = b;
    if (accept) state_d = cur;
  end

  assign ready_o = !queue_full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && (bundle_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // A bundle entering the queue is never empty and never overfull.
  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (bundle_o.cnt != '0) &&
               (bundle_o.cnt <= slt_pkg::EvCntW'(slt_pkg::MaxEvents)))
    else $error("front pushed a bundle with a bad event count");

endmodule

`default_nettype wire

/* src/slt_queue.sv */
// Short queue of event bundles between the tokenizer front and back.
`default_nettype none

module slt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire slt_pkg::bundle_t data_i,
  output      logic             full_o,
  output      logic             valid_o,
  output      slt_pkg::bundle_t data_o,
  input  wire logic             pop_i
);

  slt_pkg::bundle_t                  mem_q [slt_pkg::QueueDepth];
  logic [slt_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [slt_pkg::QueueCntW-1:0]     cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o  = (cnt_q == slt_pkg::QueueCntW'(slt_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("bundle pushed into a full queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != slt_pkg::QueueCntW'(slt_pkg::QueueDepth)) |->
      (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

/* src/slt_back.sv */
// Back of the tokenizer: plays out the events of each bundle, one per cycle while ready_i is high.
`default_nettype none

module slt_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire slt_pkg::bundle_t q_data_i,
  output      logic             q_pop_o,
  output      logic             valid_o,
  input  wire logic             ready_i,
  output      slt_pkg::event_t  event_o,
  output      logic             last_o
);

  slt_pkg::bundle_t              bundle_q;
  logic [slt_pkg::EvIdxW-1:0]    idx_q;
  logic                          busy_q;
  logic                          fire;
  logic                          need_load;

  assign last_o    = ({1'b0, idx_q} == (bundle_q.cnt - 1'b1));
  assign fire      = busy_q && ready_i;
  assign need_load = !busy_q || (fire && last_o);
  assign q_pop_o   = need_load && q_valid_i;
  assign valid_o   = busy_q;
  assign event_o   = bundle_q.ev[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fire) begin
      if (last_o) busy_q <= 1'b0;
      else idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) bundle_q <= q_data_i;
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({1'b0, idx_q} < bundle_q.cnt))
    else $error("event index past the end of its bundle");

endmodule

`default_nettype wire

/* src/shell_line_tokenizer_unit.sv */
// Top level of the shell line tokenizer: stream ports around front, queue and back.
`default_nettype none

// The tokenizer takes a command line one byte per request, the last byte of
// the line flagged on s_axis_tlast_i, and gives a stream of events: word
// bytes (word_first marks the first byte of each word), word ends, the
// operators >, >>, <, << and |, and a line end after the last byte. Quoted
// spans belong to their word, and a single > or < waits one byte to see
// whether it is doubled. m_axis_tlast_o marks the last event caused by one
// input byte. A byte is taken every cycle while the four-entry bundle queue
// between the front and the back has room; the back sends one event per
// cycle while the output is ready, and a byte that causes no events puts
// nothing in the queue. The sustained rate is set by the back's single event
// per cycle. The first event of a byte is presented on the output once its
// bundle has been written into the queue and then loaded into the back's
// bundle register.

module shell_line_tokenizer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input byte stream.
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] line_byte
  input  wire logic        s_axis_tlast_i,   // line_last
  // Output event stream.
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [15:0] m_axis_tdata_o,   // [7:0] word_char, [8] word_first, zero above
  output      logic [2:0]  m_axis_tuser_o,   // [2:0] event_kind
  output      logic        m_axis_tlast_o    // run_last
);

  logic             push;
  slt_pkg::bundle_t push_bundle;
  logic             q_full;
  logic             q_valid;
  slt_pkg::bundle_t q_bundle;
  logic             q_pop;
  slt_pkg::event_t  out_ev;

  // The front classifies each byte and collects every event it causes.
  slt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid_i),
    .ready_o      (s_axis_tready_o),
    .byte_i       (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .bundle_o     (push_bundle)
  );

  // Bundles wait here so that an output stall does not stop the input at once.
  slt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_bundle),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_bundle),
    .pop_i   (q_pop)
  );

  // The back sends the events of each bundle in order.
  slt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_bundle),
    .q_pop_o   (q_pop),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .event_o   (out_ev),
    .last_o    (m_axis_tlast_o)
  );

  // Word character is only meaningful for word bytes; the front already
  // leaves it zero for every other event.
  assign m_axis_tdata_o = {7'b0, out_ev.first, out_ev.ch};
  assign m_axis_tuser_o = out_ev.kind;

endmodule

`default_nettype wire

/* verif/slt_event_checker.sv */
`timescale 1ns / 1ps
// Event checker for the shell line tokenizer: predicts events from accepted bytes and compares.
module slt_event_checker
  import slt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] line_byte
  input  wire logic        s_tlast_i,   // line_last
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [15:0] m_tdata_i,   // [7:0] word_char, [8] word_first, zero above
  input  wire logic [2:0]  m_tuser_i,   // [2:0] event_kind
  input  wire logic        m_tlast_i,   // run_last
  output int unsigned      fail_cnt_o,
  output int unsigned      due_cnt_o
);

  typedef enum logic [2:0] {
    LexIdle   = 3'd0,
    LexWord   = 3'd1,
    LexSQuote = 3'd2,
    LexDQuote = 3'd3,
    LexGtWait = 3'd4,
    LexLtWait = 3'd5
  } lex_state_e;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  ch;
    logic        first;
    logic        tail;
  } lex_event_t;

  lex_event_t events_due[$];
  lex_state_e lex_st = LexIdle;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'h00) || (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  function automatic bit is_oper(input logic [7:0] c);
    return (c == CharGt) || (c == CharLt) || (c == CharPipe);
  endfunction

  function automatic lex_event_t mk_event(input event_kind_e k, input logic [7:0] c,
                                          input logic f);
    lex_event_t e;
    e.kind  = k;
    e.ch    = c;
    e.first = f;
    e.tail  = 1'b0;
    return e;
  endfunction

  // Works out every event one byte causes and queues them in order.
  function automatic void lex_byte(input logic [7:0] c, input logic lst);
    lex_event_t run[$];
    lex_state_e st;
    logic [7:0] quote;
    bit         done;
    st   = lex_st;
    done = 1'b0;
    if (st == LexSQuote || st == LexDQuote) begin
      quote = (st == LexSQuote) ? CharSQuote : CharDQuote;
      run.push_back(mk_event(EvByte, c, 1'b0));
      if (c == quote) st = LexWord;
      done = 1'b1;
    end else if (st == LexGtWait || st == LexLtWait) begin
      if (c == ((st == LexGtWait) ? CharGt : CharLt)) begin
        run.push_back(mk_event((st == LexGtWait) ? EvAppend : EvHeredoc, 8'h00, 1'b0));
        done = 1'b1;
      end else begin
        run.push_back(mk_event((st == LexGtWait) ? EvOut : EvIn, 8'h00, 1'b0));
      end
      st = LexIdle;
    end

    if (!done) begin
      if (is_blank(c)) begin
        if (st == LexWord) run.push_back(mk_event(EvWordEnd, 8'h00, 1'b0));
        st = LexIdle;
      end else if (is_oper(c)) begin
        if (st == LexWord) run.push_back(mk_event(EvWordEnd, 8'h00, 1'b0));
        if (c == CharGt) begin
          st = LexGtWait;
        end else if (c == CharLt) begin
          st = LexLtWait;
        end else begin
          run.push_back(mk_event(EvPipe, 8'h00, 1'b0));
          st = LexIdle;
        end
      end else begin
        run.push_back(mk_event(EvByte, c, (st == LexWord) ? 1'b0 : 1'b1));
        if (c == CharSQuote)      st = LexSQuote;
        else if (c == CharDQuote) st = LexDQuote;
        else                      st = LexWord;
      end
    end

    if (lst) begin
      if (st == LexWord || st == LexSQuote || st == LexDQuote)
        run.push_back(mk_event(EvWordEnd, 8'h00, 1'b0));
      else if (st == LexGtWait)
        run.push_back(mk_event(EvOut, 8'h00, 1'b0));
      else if (st == LexLtWait)
        run.push_back(mk_event(EvIn, 8'h00, 1'b0));
      run.push_back(mk_event(EvLineEnd, 8'h00, 1'b0));
      st = LexIdle;
    end

    if (run.size() > 0) run[run.size()-1].tail = 1'b1;
    foreach (run[i]) events_due.push_back(run[i]);
    lex_st = st;
  endfunction

  function automatic void report(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    fail_cnt_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lex_event_t due_ev;
    if (!rst_ni) begin
      lex_st = LexIdle;
      events_due.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (events_due.size() == 0) begin
          $display("%0t: event with none expected, expected nothing, actual kind %0d data 0x%0h",
                   $time, m_tuser_i, m_tdata_i);
          fail_cnt_o++;
        end else begin
          due_ev = events_due.pop_front();
          if (m_tuser_i !== due_ev.kind)   report("event_kind", due_ev.kind, m_tuser_i);
          if (m_tdata_i[7:0] !== due_ev.ch) report("word_char", due_ev.ch, m_tdata_i[7:0]);
          if (m_tdata_i[8] !== due_ev.first) report("word_first", due_ev.first, m_tdata_i[8]);
          if (m_tdata_i[15:9] !== 7'd0)    report("tdata padding", 0, m_tdata_i[15:9]);
          if (m_tlast_i !== due_ev.tail)   report("run_last", due_ev.tail, m_tlast_i);
        end
      end
      if (s_tvalid_i && s_tready_i) lex_byte(s_tdata_i, s_tlast_i);
    end
    due_cnt_o = events_due.size();
  end

endmodule

/* verif/tb_shell_line_tokenizer_unit.sv */
`timescale 1ns / 1ps
// Top of the shell line tokenizer testbench: clock, reset, byte stimulus, receiver and verdict.
module tb_shell_line_tokenizer_unit;
  import slt_pkg::*;

  // Number of random bytes to send after the directed lines.
  localparam int unsigned RandomBytes = 440;
  // Wait after the last event due, so that any event the block might add
  // after the last one due is caught.
  localparam int unsigned DrainCycles = 20;
  // Length of the long receiver hold-off that lets the bundle queue fill.
  localparam int unsigned HoldCycles  = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  int unsigned fail_cnt;
  int unsigned due_cnt;

  // The stimulus process asks for a long hold-off by raising hold_asked;
  // the receiver process serves it and counts it in hold_done.
  int unsigned hold_asked = 0;
  int unsigned hold_done  = 0;

  // Sender burst bookkeeping and the bytes of the line being built.
  int unsigned burst_left = 0;
  logic [7:0]  line_q[$];

  // Whitespace codes the lexer treats as separators, the zero byte among them.
  logic [7:0] blank_set[7] = '{CharSpace, CharTab, CharCr, 8'h0A, 8'h0B, 8'h0C, 8'h00};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  shell_line_tokenizer_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  slt_event_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_valid),
    .s_tready_i (s_ready),
    .s_tdata_i  (s_data),
    .s_tlast_i  (s_last),
    .m_tvalid_i (m_valid),
    .m_tready_i (m_ready),
    .m_tdata_i  (m_data),
    .m_tuser_i  (m_user),
    .m_tlast_i  (m_last),
    .fail_cnt_o (fail_cnt),
    .due_cnt_o  (due_cnt)
  );

  // Sends one byte as a request. The sender works in bursts; when a burst is
  // used up it may leave the stream idle before the next.
  // Every change happens at a falling edge, and the handshake is judged at
  // the rising edge, so the block and the checker see the same request.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= lst;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  // Sends the characters of a string, flagging the last one when asked.
  task automatic send_text(input string s, input bit end_line);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_line && (i == s.len() - 1));
  endtask

  // Any byte that is part of a plain word: no whitespace, operator or quote.
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 255));
    while (b == CharGt || b == CharLt || b == CharPipe || b == CharSQuote || b == CharDQuote);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return blank_set[$urandom_range(0, 6)];
  endfunction

  // Builds one command line in line_q. Most lines are made of words, quoted
  // spans and operators with whitespace between them, so that every lexer
  // state is reached; about one in five is plain noise of arbitrary bytes.
  task automatic make_line();
    int unsigned n_tok;
    logic [7:0]  quote;
    logic [7:0]  b;
    line_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) line_q.push_back(blank_byte());
      n_tok = $urandom_range(1, 8);
      repeat (n_tok) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            repeat ($urandom_range(1, 5)) line_q.push_back(word_byte());
          end
          4, 5: begin
            // A quoted span, sometimes glued to a word, rarely left open.
            if ($urandom_range(0, 2) == 0) line_q.push_back(word_byte());
            quote = $urandom_range(0, 1) ? CharSQuote : CharDQuote;
            line_q.push_back(quote);
            repeat ($urandom_range(0, 6)) begin
              do b = 8'($urandom_range(1, 255)); while (b == quote);
              line_q.push_back(b);
            end
            if ($urandom_range(0, 5) != 0) line_q.push_back(quote);
          end
          6: line_q.push_back(CharPipe);
          7: begin
            repeat ($urandom_range(1, 3)) line_q.push_back(CharGt);
          end
          default: begin
            repeat ($urandom_range(1, 3)) line_q.push_back(CharLt);
          end
        endcase
        if ($urandom_range(0, 9) < 7) begin
          repeat ($urandom_range(1, 3)) line_q.push_back(blank_byte());
        end
      end
    end
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  // Receiver: ready follows phases of its own, always ready, half ready or
  // mostly stalled, each for a random stretch. A requested long hold-off
  // keeps ready low while the sender goes on.
  initial begin : rx_pattern
    int unsigned phase_left;
    int unsigned mode;
    phase_left = 0;
    mode       = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_done) begin
        m_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_done++;
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 2);
          phase_left = $urandom_range(5, 40);
        end
        phase_left--;
        case (mode)
          0:       m_ready <= 1'b1;
          1:       m_ready <= 1'($urandom_range(0, 1));
          default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Main stimulus: reset, directed lines, random lines, drain and verdict.
  initial begin : stimulus
    int unsigned sent;
    bit          held;
    bit          drained;
    sent    = 0;
    held    = 1'b0;
    drained = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A one-byte line with every data bit set.
    send_byte(8'hFF, 1'b1);
    // A tripled > gives append, then a pending > that a plain byte resolves.
    send_text(">>>x", 1'b1);
    // A tripled < leaves a pending < that the line end emits.
    send_text("<<<", 1'b1);
    // An unterminated single quote swallows the pipe and closes at the line end.
    send_text("'a|", 1'b1);
    // An open double quote holding an operator and a tab.
    send_text("q\"<\t", 1'b1);
    // A closed double quote followed by more of the same word.
    send_text("\"b\"c", 1'b1);
    // Pipe, a word ended by a zero byte, then trailing whitespace.
    send_text("|c", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CharSpace, 1'b1);

    while (sent < RandomBytes) begin
      make_line();
      send_line();
      sent += line_q.size();
      if (!held && sent > 150) begin
        // Stall the output for a long stretch while bytes keep coming.
        hold_asked++;
        held = 1'b1;
      end
      if (!drained && sent > 320) begin
        // Stop offering bytes until every predicted event has arrived.
        s_valid <= 1'b0;
        while (due_cnt != 0) @(negedge clk);
        @(negedge clk);
        burst_left = 0;
        drained    = 1'b1;
      end
    end

    s_valid <= 1'b0;
    while (due_cnt != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("tb_shell_line_tokenizer_unit passed");
    end else begin
      $display("tb_shell_line_tokenizer_unit failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #400000;
    $display("tb_shell_line_tokenizer_unit failed");
    $finish;
  end

endmodule
